[hw/rtl/sequential_list_table_macros.svh]
// assertion macros for the sequential list table
`ifndef SEQUENTIAL_LIST_TABLE_MACROS_SVH
`define SEQUENTIAL_LIST_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SLT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequential list table check failed");

// next-cycle implication, checked outside reset
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequential list table check failed");

`endif

[hw/rtl/slt_pkg.sv]
// shared types and codes for the sequential list table
package slt_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_DUMP   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic               en;
    logic [VALUE_W-1:0] data;
  } slt_wr_t;

endpackage

[hw/rtl/slt_mem.sv]
// entry storage: one write port, one registered read port
module slt_mem #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  slt_pkg::slt_wr_t            wr,
  input  logic [AW-1:0]               waddr,
  input  logic                        rd_en,
  input  logic [AW-1:0]               raddr,
  output logic [slt_pkg::VALUE_W-1:0] rdata
);

  logic [slt_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/sequential_list_table.sv]
// append, change and any single-result operation: result registered from the op state
// delete walks the list, its result registered from the finish state after the walk; dump:
// entries follow one entry per cycle unless the output side stalls
// one item at a time: the sequencer returns to idle as the final result is loaded
// rst clears the count and the control state; the entry memory is not cleared
`include "sequential_list_table_macros.svh"

module sequential_list_table #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // entry_position[6:0], entry_value[38:7],
                                 // entry_count[45:39], removed[52:46], zero pad
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  localparam int unsigned AW    = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned VW    = slt_pkg::VALUE_W;
  localparam int unsigned PW    = slt_pkg::POS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_WALK,
    ST_FIN
  } state_t;

  state_t              state;
  logic [1:0]          kind;
  logic [PW-1:0]       pos;
  logic [VW-1:0]       val;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    rp;
  logic [CNT_W-1:0]    wp;
  logic [AW-1:0]       ri;
  logic                dv;

  logic                out_free;
  logic                is_del;
  logic                consume;
  logic                issue;
  logic                keep;
  logic                ri_last;
  logic                full;
  logic                bad_pos;
  logic [PW-1:0]       pos_m1;
  logic [VW-1:0]       rdata;

  slt_pkg::slt_wr_t    mem_wr;
  logic [AW-1:0]       mem_waddr;

  logic                em_valid;
  logic [1:0]          em_status;
  logic [PW-1:0]       em_pos;
  logic [VW-1:0]       em_value;
  logic [PW-1:0]       em_count;
  logic [PW-1:0]       em_removed;
  logic                em_last;
  logic                done;
  logic                to_walk;
  logic                to_fin;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign is_del   = (kind == slt_pkg::KIND_DELETE);
  assign consume  = (state == ST_WALK) && dv && (is_del || out_free);
  assign issue    = (state == ST_WALK) && (rp < count) && (!dv || consume);
  assign keep     = (rdata != val);
  assign ri_last  = (CNT_W'(ri) == count - CNT_W'(1));
  assign full     = (count == CNT_W'(LIST_DEPTH));
  assign bad_pos  = (pos == '0) || (pos > PW'(count));
  assign pos_m1   = pos - PW'(1);

  // memory write port: append, change, or compaction during delete
  always_comb begin
    mem_wr.en   = 1'b0;
    mem_wr.data = val;
    mem_waddr   = count[AW-1:0];
    if (state == ST_OP && out_free) begin
      if (kind == slt_pkg::KIND_APPEND && !full) begin
        mem_wr.en = 1'b1;
      end else if (kind == slt_pkg::KIND_CHANGE && !bad_pos) begin
        mem_wr.en = 1'b1;
        mem_waddr = pos_m1[AW-1:0];
      end
    end else if (consume && is_del && keep) begin
      mem_wr.en   = 1'b1;
      mem_wr.data = rdata;
      mem_waddr   = wp[AW-1:0];
    end
  end

  slt_mem #(
    .DEPTH (LIST_DEPTH)
  ) u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .waddr (mem_waddr),
    .rd_en (issue),
    .raddr (rp[AW-1:0]),
    .rdata (rdata)
  );

  // result for this cycle and where the sequencer goes
  always_comb begin
    em_valid   = 1'b0;
    em_status  = slt_pkg::ST_OK;
    em_pos     = '0;
    em_value   = '0;
    em_count   = PW'(count);
    em_removed = '0;
    em_last    = 1'b1;
    done       = 1'b0;
    to_walk    = 1'b0;
    to_fin     = 1'b0;
    unique case (state)
      ST_OP: begin
        unique case (kind)
          slt_pkg::KIND_APPEND: begin
            em_valid  = out_free;
            em_status = full ? slt_pkg::ST_FULL : slt_pkg::ST_OK;
            em_count  = full ? PW'(count) : PW'(count) + PW'(1);
          end
          slt_pkg::KIND_CHANGE: begin
            em_valid  = out_free;
            em_status = bad_pos ? slt_pkg::ST_BADPOS : slt_pkg::ST_OK;
          end
          slt_pkg::KIND_DELETE, slt_pkg::KIND_DUMP: begin
            if (count == '0) begin
              em_valid  = out_free;
              em_status = slt_pkg::ST_EMPTY;
            end else begin
              to_walk = 1'b1;
            end
          end
          default: begin
            em_valid = out_free;
          end
        endcase
        done = em_valid;
      end
      ST_WALK: begin
        if (consume && !is_del) begin
          em_valid = 1'b1;
          em_pos   = PW'(ri) + PW'(1);
          em_value = rdata;
          em_last  = ri_last;
          done     = ri_last;
        end
        to_fin = consume && is_del && ri_last;
      end
      ST_FIN: begin
        em_valid   = out_free;
        em_count   = PW'(wp);
        em_removed = PW'(count - wp);
        done       = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      dv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (em_valid) begin
        m_tvalid <= 1'b1;
        m_tuser  <= em_status;
        m_tlast  <= em_last;
        m_tdata  <= {3'b000, em_removed, em_count, em_value, em_pos};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (state == ST_IDLE && s_tvalid) begin
        kind  <= s_tuser;
        pos   <= s_tdata[PW-1:0];
        val   <= s_tdata[PW+VW-1:PW];
        state <= ST_OP;
      end else if (to_walk) begin
        rp    <= '0;
        wp    <= '0;
        dv    <= 1'b0;
        state <= ST_WALK;
      end else if (to_fin) begin
        state <= ST_FIN;
      end else if (done) begin
        state <= ST_IDLE;
      end

      if (state == ST_OP && done && kind == slt_pkg::KIND_APPEND && !full) begin
        count <= count + CNT_W'(1);
      end else if (state == ST_FIN && done) begin
        count <= wp;
      end

      if (state == ST_WALK) begin
        if (issue) begin
          ri <= rp[AW-1:0];
          rp <= rp + CNT_W'(1);
          dv <= 1'b1;
        end else if (consume) begin
          dv <= 1'b0;
        end
        if (consume && is_del && keep) begin
          wp <= wp + CNT_W'(1);
        end
      end
    end
  end

  `SLT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(LIST_DEPTH))
  `SLT_ASSERT_NOW(a_no_rw_clash, clk, rst, mem_wr.en && issue, mem_waddr != rp[AW-1:0])
  `SLT_ASSERT_NOW(a_wp_behind_rp, clk, rst, state == ST_WALK, wp <= rp)
  `SLT_ASSERT_NEXT(a_fin_shrinks, clk, rst, state == ST_FIN && done, count <= $past(count))

endmodule
